// ===== hw/rtl/ssc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ssc_pkg;

  localparam int unsigned CFG_ADDR_W  = 6;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam int unsigned REG_IDX_W   = CFG_ADDR_W - REG_IDX_LSB;

  localparam logic [REG_IDX_W-1:0] REG_KEY01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY23 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY45 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY67 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONCE = 3'd4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] state_t;

  typedef struct packed {
    logic [63:0] key01;
    logic [63:0] key23;
    logic [63:0] key45;
    logic [63:0] key67;
    logic [63:0] nonce;
  } cfg_t;

  typedef struct packed {
    logic        need_block;
    logic [63:0] ctr;
    logic [2:0]  pos;
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        last;
  } item_t;

  // quarter-round word indices a, b, c, d
  localparam logic [3:0] COL_IDX [4][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11}
  };
  localparam logic [3:0] ROW_IDX [4][4] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic state_t init_state(input cfg_t cfg, input logic [63:0] ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = cfg.key01[31:0];
    s[2]  = cfg.key01[63:32];
    s[3]  = cfg.key23[31:0];
    s[4]  = cfg.key23[63:32];
    s[5]  = SIGMA1;
    s[6]  = cfg.nonce[31:0];
    s[7]  = cfg.nonce[63:32];
    s[8]  = ctr[31:0];
    s[9]  = ctr[63:32];
    s[10] = SIGMA2;
    s[11] = cfg.key45[31:0];
    s[12] = cfg.key45[63:32];
    s[13] = cfg.key67[31:0];
    s[14] = cfg.key67[63:32];
    s[15] = SIGMA3;
    return s;
  endfunction

  // Two of the four quarter-round steps on all four groups of one round.
  function automatic state_t half_round(input state_t w, input logic row, input logic second);
    state_t     r;
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    r = w;
    for (int q = 0; q < 4; q++) begin
      ia = row ? ROW_IDX[q][0] : COL_IDX[q][0];
      ib = row ? ROW_IDX[q][1] : COL_IDX[q][1];
      ic = row ? ROW_IDX[q][2] : COL_IDX[q][2];
      id = row ? ROW_IDX[q][3] : COL_IDX[q][3];
      if (!second) begin
        r[ib] = r[ib] ^ rotl(r[ia] + r[id], 7);
        r[ic] = r[ic] ^ rotl(r[ib] + r[ia], 9);
      end else begin
        r[id] = r[id] ^ rotl(r[ic] + r[ib], 13);
        r[ia] = r[ia] ^ rotl(r[id] + r[ic], 18);
      end
    end
    return r;
  endfunction

  function automatic state_t add_state(input state_t w, input state_t s);
    state_t r;
    for (int i = 0; i < 16; i++) begin
      r[i] = w[i] + s[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_first,
  input  wire logic [63:0]    in_chunk_in,
  input  wire logic [3:0]     in_valid_bytes,
  input  wire logic           in_last,
  input  wire logic           q_full,
  output logic                q_push,
  output ssc_pkg::item_t      q_item
);

  logic [63:0] ctr_r;
  logic [63:0] ctr_nxt;
  logic [2:0]  pos_r;
  logic [2:0]  pos_nxt;
  logic [63:0] eff_ctr;
  logic [2:0]  eff_pos;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // first restarts the message before this item is placed
  assign eff_ctr = in_first ? '0 : ctr_r;
  assign eff_pos = in_first ? '0 : pos_r;

  always_comb begin
    q_item.need_block = (eff_pos == 3'd0);
    q_item.ctr        = eff_ctr;
    q_item.pos        = eff_pos;
    q_item.chunk      = in_chunk_in;
    q_item.nbytes     = in_valid_bytes;
    q_item.last       = in_last;
  end

  always_comb begin
    pos_nxt = pos_r;
    ctr_nxt = ctr_r;
    if (q_push) begin
      pos_nxt = eff_pos + 3'd1;
      ctr_nxt = (eff_pos == 3'd7) ? eff_ctr + 64'd1 : eff_ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ctr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      ctr_r <= ctr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ssc_pkg::item_t  push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output ssc_pkg::item_t       head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssc_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("item pushed into a full queue");
  pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("item popped from an empty queue");
  count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count lost a pushed item");

endmodule
`default_nettype wire

// ===== hw/rtl/ssc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ssc_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ssc_pkg::cfg_t   cfg,
  input  wire logic            head_valid,
  input  wire ssc_pkg::item_t  head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [63:0]          out_chunk_out,
  output logic [3:0]           out_valid_bytes_out,
  output logic                 out_last_out
);

  localparam int unsigned STEPS  = 4 * DOUBLE_ROUNDS;
  localparam int unsigned STEP_W = $clog2(STEPS);

  typedef enum logic [3:0] {
    B_WAIT  = 4'b0001,
    B_ROUND = 4'b0010,
    B_ADD   = 4'b0100,
    B_EMIT  = 4'b1000
  } bstate_t;

  bstate_t           state_r;
  bstate_t           state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  ssc_pkg::state_t   work_r;
  ssc_pkg::state_t   work_nxt;
  ssc_pkg::state_t   init_st;
  logic              slot_free;
  logic              emit;
  logic [63:0]       ks;
  logic [63:0]       chunk_x;
  logic              out_valid_r;
  logic [63:0]       out_chunk_r;
  logic [3:0]        out_nbytes_r;
  logic              out_last_r;

  // the queued item stays put until popped; the user must hold key and nonce until then, the block does not enforce it
  assign init_st   = ssc_pkg::init_state(cfg, head_item.ctr);
  assign slot_free = !out_valid_r || out_ready;
  assign pop       = emit;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    work_nxt  = work_r;
    emit      = 1'b0;
    unique case (state_r)
      B_WAIT: begin
        if (head_valid) begin
          if (head_item.need_block) begin
            work_nxt  = init_st;
            step_nxt  = '0;
            state_nxt = B_ROUND;
          end else if (slot_free) begin
            emit = 1'b1;
          end
        end
      end
      B_ROUND: begin
        // step bit 1 picks column or row round, bit 0 the half
        work_nxt = ssc_pkg::half_round(work_r, step_r[1], step_r[0]);
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = B_ADD;
        end
      end
      B_ADD: begin
        work_nxt  = ssc_pkg::add_state(work_r, init_st);
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = B_WAIT;
        end
      end
      default: begin
        state_nxt = B_WAIT;
      end
    endcase
  end

  // keystream chunk p is words 2p and 2p+1, low word first
  assign ks = {work_r[{head_item.pos, 1'b1}], work_r[{head_item.pos, 1'b0}]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chunk_x[8*i +: 8] = (4'(i) < head_item.nbytes) ?
                          (head_item.chunk[8*i +: 8] ^ ks[8*i +: 8]) : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (emit) begin
      out_chunk_r  <= chunk_x;
      out_nbytes_r <= head_item.nbytes;
      out_last_r   <= head_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_WAIT;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_chunk_out       = out_chunk_r;
  assign out_valid_bytes_out = out_nbytes_r;
  assign out_last_out        = out_last_r;

  round_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROUND) |-> (head_valid && head_item.need_block))
    else $error("rounds running without a block-start item at the head");
  add_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADD) |=> (state_r == B_EMIT))
    else $error("final add not followed by emit");
  no_stale_keystream: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (state_r == B_WAIT)) |-> !head_item.need_block)
    else $error("block-start item emitted with an old keystream block");
  emit_waits_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$past(emit))
    else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

// ===== hw/rtl/salsa20_stream_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Salsa20 stream cipher over 8-byte chunks. Write the key and nonce over the
// register port (64-bit registers at byte addresses 0x00..0x20) while the block
// is idle, then send chunks with first set on the opening chunk of a message.
// Each chunk comes back XORed with the next 8 keystream bytes, bytes past
// valid_bytes zeroed. The front tracks block counter and position and queues
// items; the back computes a keystream block whenever a chunk opens one. The
// round unit does two quarter-round steps per cycle. A chunk that opens a block
// passes through the round, add and emit states in the back; the other seven
// chunks of a block are XORed with the held block as the output slot frees.
module salsa20_stream_cipher #(
  parameter int unsigned DOUBLE_ROUNDS = 10,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ssc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [ssc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [ssc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_first,
  input  wire logic [63:0]                      in_chunk_in,
  input  wire logic [3:0]                       in_valid_bytes,
  input  wire logic                             in_last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [63:0]                           out_chunk_out,
  output logic [3:0]                            out_valid_bytes_out,
  output logic                                  out_last_out
);

  ssc_pkg::cfg_t                    cfg_r;
  logic                             wr_en;
  logic [ssc_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                             q_full;
  logic                             q_push;
  ssc_pkg::item_t                   q_item;
  logic                             q_pop;
  logic                             head_valid;
  ssc_pkg::item_t                   head_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ssc_pkg::CFG_ADDR_W-1:ssc_pkg::REG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        ssc_pkg::REG_KEY01: cfg_r.key01 <= pwdata;
        ssc_pkg::REG_KEY23: cfg_r.key23 <= pwdata;
        ssc_pkg::REG_KEY45: cfg_r.key45 <= pwdata;
        ssc_pkg::REG_KEY67: cfg_r.key67 <= pwdata;
        ssc_pkg::REG_NONCE: cfg_r.nonce <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ssc_pkg::REG_KEY01: prdata = cfg_r.key01;
      ssc_pkg::REG_KEY23: prdata = cfg_r.key23;
      ssc_pkg::REG_KEY45: prdata = cfg_r.key45;
      ssc_pkg::REG_KEY67: prdata = cfg_r.key67;
      ssc_pkg::REG_NONCE: prdata = cfg_r.nonce;
      default:            prdata = '0;
    endcase
  end

  ssc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first       (in_first),
    .in_chunk_in    (in_chunk_in),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  ssc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ssc_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_chunk_out       (out_chunk_out),
    .out_valid_bytes_out (out_valid_bytes_out),
    .out_last_out        (out_last_out)
  );

endmodule
`default_nettype wire
